// ===== rtl/core/tga_rle_image_decoder_defines.svh =====
// Assertion macros shared by the TGA decoder RTL.
// Depends on nothing; files that check their own logic include it.
`ifndef TGA_RLE_IMAGE_DECODER_DEFINES_SVH
`define TGA_RLE_IMAGE_DECODER_DEFINES_SVH

`ifndef SYNTHESIS
// Same-cycle implication, checked outside reset
`define TGAD_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tgad: same-cycle check failed");
// Next-cycle implication, checked outside reset
`define TGAD_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tgad: next-cycle check failed");
`else
`define TGAD_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define TGAD_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

// ===== rtl/core/tgad_pkg.sv =====
// Types and constants of the TGA RLE image decoder.
// No dependencies; used by tgad_in_reg, tgad_decode, tgad_out_reg and the top.
`default_nettype none

package tgad_pkg;

    // Decoder phase
    typedef enum logic [2:0] {
        PH_HEADER,
        PH_SKIP,
        PH_DATA,
        PH_DONE,
        PH_STOP
    } t_phase;

    // Input item kinds
    localparam logic [1:0] KIND_BYTE = 2'd0;
    localparam logic [1:0] KIND_CONT = 2'd1;
    localparam logic [1:0] KIND_EOF  = 2'd2;
    localparam logic [1:0] KIND_RSVD = 2'd3;

    // Result status codes
    localparam logic [2:0] ST_PIXEL     = 3'd0;
    localparam logic [2:0] ST_BAD_TYPE  = 3'd1;
    localparam logic [2:0] ST_BAD_DEPTH = 3'd2;
    localparam logic [2:0] ST_ZERO_SIZE = 3'd3;
    localparam logic [2:0] ST_TRUNC     = 3'd4;
    localparam logic [2:0] ST_TOO_LARGE = 3'd5;

    // Header byte positions
    localparam logic [4:0] HDR_ID_LEN  = 5'd0;
    localparam logic [4:0] HDR_TYPE    = 5'd2;
    localparam logic [4:0] HDR_W_LO    = 5'd12;
    localparam logic [4:0] HDR_W_HI    = 5'd13;
    localparam logic [4:0] HDR_H_LO    = 5'd14;
    localparam logic [4:0] HDR_H_HI    = 5'd15;
    localparam logic [4:0] HDR_DEPTH   = 5'd16;
    localparam logic [4:0] HDR_DESC    = 5'd17;

    // Header field values
    localparam logic [7:0] TYPE_RAW  = 8'd2;
    localparam logic [7:0] TYPE_RLE  = 8'd10;
    localparam logic [7:0] DEPTH_24  = 8'd24;
    localparam logic [7:0] DEPTH_32  = 8'd32;
    localparam int         DESC_TOP_BIT = 5;

    localparam int IDX_W = 20;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] data_byte;
    } t_item;

    typedef struct packed {
        logic [2:0]       status;
        logic [IDX_W-1:0] pixel_index;
        logic [7:0]       blue;
        logic [7:0]       green;
        logic [7:0]       red;
        logic [7:0]       alpha;
        logic             last_pixel;
        logic             run_pending;
        logic [15:0]      image_width;
        logic [15:0]      image_height;
    } t_result;

endpackage

`default_nettype wire

// ===== rtl/core/tgad_ifs.sv =====
// Valid/ready channel interfaces of the TGA decoder: input items and results.
// Depends on nothing; widths follow tgad_pkg's item and result fields.
`default_nettype none

interface tgad_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] kind;
    logic [7:0] data_byte;

    modport source (output valid, output kind, output data_byte, input ready);
    modport sink   (input valid, input kind, input data_byte, output ready);
endinterface

interface tgad_out_if;
    logic        valid;
    logic        ready;
    logic [2:0]  status;
    logic [19:0] pixel_index;
    logic [7:0]  blue;
    logic [7:0]  green;
    logic [7:0]  red;
    logic [7:0]  alpha;
    logic        last_pixel;
    logic        run_pending;
    logic [15:0] image_width;
    logic [15:0] image_height;

    modport source (output valid, output status, output pixel_index, output blue,
                    output green, output red, output alpha, output last_pixel,
                    output run_pending, output image_width, output image_height,
                    input ready);
    modport sink   (input valid, input status, input pixel_index, input blue,
                    input green, input red, input alpha, input last_pixel,
                    input run_pending, input image_width, input image_height,
                    output ready);
endinterface

`default_nettype wire

// ===== rtl/core/tgad_in_reg.sv =====
// Input register of the TGA decoder: holds one accepted item for the decode stage.
// Depends on tgad_pkg and tgad_in_if.
`default_nettype none

module tgad_in_reg (
    input  wire             i_clk,
    input  wire             i_rst_n,
    tgad_in_if.sink         i_in,
    input  wire             i_advance,
    output logic            o_valid,
    output tgad_pkg::t_item o_item
);

    logic            r_valid;
    tgad_pkg::t_item r_item;

    // Take a new item when empty or whenever the held one moves on this cycle
    assign i_in.ready = !r_valid || i_advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.ready && i_in.valid) begin
            r_item.kind      <= i_in.kind;
            r_item.data_byte <= i_in.data_byte;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

`default_nettype wire

// ===== rtl/core/tgad_decode.sv =====
// Decode stage of the TGA decoder: header parser, ID skip, pixel/RLE state.
// Depends on tgad_pkg and tga_rle_image_decoder_defines.svh.
`default_nettype none
`include "tga_rle_image_decoder_defines.svh"

module tgad_decode #(
    parameter int MAX_PIXELS = 1048576
) (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               i_step,
    input  tgad_pkg::t_item   i_item,
    output logic              o_res_valid,
    output tgad_pkg::t_result o_res
);

    localparam int CNT_W = $clog2(MAX_PIXELS + 1);
    localparam int IDX_W = tgad_pkg::IDX_W;

    // State
    tgad_pkg::t_phase r_phase, n_phase;
    logic [4:0]       r_hdr_cnt, n_hdr_cnt;
    logic [7:0]       r_id_skip, n_id_skip;
    logic             r_rle, n_rle;
    logic             r_four, n_four;
    logic             r_flip, n_flip;
    logic [15:0]      r_width, n_width;
    logic [15:0]      r_height, n_height;
    logic [1:0]       r_pbc, n_pbc;
    logic [31:0]      r_latch, n_latch;
    logic [7:0]       r_packet_left, n_packet_left;
    logic             r_repeat, n_repeat;
    logic [15:0]      r_column, n_column;
    logic [IDX_W-1:0] r_row_start, n_row_start;
    logic [CNT_W-1:0] r_pix_left, n_pix_left;
    logic             r_type_bad, n_type_bad;
    logic             r_depth_bad, n_depth_bad;
    logic             r_run_active, n_run_active;
    logic [31:0]      r_total;

    logic             w_pending;
    logic             w_emit;
    logic             w_err;
    logic [2:0]       w_err_st;
    logic [IDX_W-1:0] w_idx;
    logic             w_last;

    // Image size product; width and height settle two header bytes before the check
    always_ff @(posedge i_clk) begin
        r_total <= 32'(r_width) * 32'(r_height);
    end

    assign w_pending = (r_phase == tgad_pkg::PH_DATA) && r_run_active;

    // Next state
    always_comb begin
        n_phase       = r_phase;
        n_hdr_cnt     = r_hdr_cnt;
        n_id_skip     = r_id_skip;
        n_rle         = r_rle;
        n_four        = r_four;
        n_flip        = r_flip;
        n_width       = r_width;
        n_height      = r_height;
        n_pbc         = r_pbc;
        n_latch       = r_latch;
        n_packet_left = r_packet_left;
        n_repeat      = r_repeat;
        n_column      = r_column;
        n_row_start   = r_row_start;
        n_pix_left    = r_pix_left;
        n_type_bad    = r_type_bad;
        n_depth_bad   = r_depth_bad;
        n_run_active  = r_run_active;
        w_emit        = 1'b0;
        w_err         = 1'b0;
        w_err_st      = tgad_pkg::ST_PIXEL;
        w_idx         = '0;
        w_last        = 1'b0;

        if (i_step) begin
            if (i_item.kind == tgad_pkg::KIND_RSVD || r_phase == tgad_pkg::PH_DONE ||
                r_phase == tgad_pkg::PH_STOP) begin
                // ignored
            end else if (i_item.kind == tgad_pkg::KIND_EOF) begin
                // end of file is only harmless while a repeat run is draining
                if (!w_pending) begin
                    w_err    = 1'b1;
                    w_err_st = tgad_pkg::ST_TRUNC;
                end
            end else if (w_pending) begin
                // next copy of a repeat packet; any byte value is dropped
                n_packet_left = r_packet_left - 8'd1;
                if (r_packet_left == 8'd1) begin
                    n_run_active = 1'b0;
                end
                w_emit = 1'b1;
            end else if (i_item.kind == tgad_pkg::KIND_CONT) begin
                // nothing to continue
            end else begin
                case (r_phase)
                    tgad_pkg::PH_HEADER: begin
                        case (r_hdr_cnt)
                            tgad_pkg::HDR_ID_LEN: n_id_skip = i_item.data_byte;
                            tgad_pkg::HDR_TYPE: begin
                                n_type_bad = (i_item.data_byte != tgad_pkg::TYPE_RAW) &&
                                             (i_item.data_byte != tgad_pkg::TYPE_RLE);
                                n_rle      = (i_item.data_byte == tgad_pkg::TYPE_RLE);
                            end
                            tgad_pkg::HDR_W_LO: n_width[7:0]   = i_item.data_byte;
                            tgad_pkg::HDR_W_HI: n_width[15:8]  = i_item.data_byte;
                            tgad_pkg::HDR_H_LO: n_height[7:0]  = i_item.data_byte;
                            tgad_pkg::HDR_H_HI: n_height[15:8] = i_item.data_byte;
                            tgad_pkg::HDR_DEPTH: begin
                                n_depth_bad = (i_item.data_byte != tgad_pkg::DEPTH_24) &&
                                              (i_item.data_byte != tgad_pkg::DEPTH_32);
                                n_four      = (i_item.data_byte == tgad_pkg::DEPTH_32);
                            end
                            tgad_pkg::HDR_DESC:
                                n_flip = !i_item.data_byte[tgad_pkg::DESC_TOP_BIT];
                            default: ;
                        endcase

                        if (r_hdr_cnt >= tgad_pkg::HDR_DESC) begin
                            // header complete: checks in priority order
                            n_hdr_cnt = '0;
                            if (r_type_bad) begin
                                w_err    = 1'b1;
                                w_err_st = tgad_pkg::ST_BAD_TYPE;
                            end else if (r_depth_bad) begin
                                w_err    = 1'b1;
                                w_err_st = tgad_pkg::ST_BAD_DEPTH;
                            end else if (r_total == 32'd0) begin
                                w_err    = 1'b1;
                                w_err_st = tgad_pkg::ST_ZERO_SIZE;
                            end else if (r_total > 32'(MAX_PIXELS)) begin
                                w_err    = 1'b1;
                                w_err_st = tgad_pkg::ST_TOO_LARGE;
                            end else begin
                                n_pix_left    = r_total[CNT_W-1:0];
                                n_column      = '0;
                                // bottom-up files start at the last row: (h-1)*w
                                n_row_start   = n_flip ?
                                                IDX_W'(r_total - 32'(r_width)) : '0;
                                n_pbc         = '0;
                                n_latch       = '0;
                                n_packet_left = '0;
                                n_repeat      = 1'b0;
                                n_run_active  = 1'b0;
                                n_phase       = (r_id_skip != 8'd0) ?
                                                tgad_pkg::PH_SKIP : tgad_pkg::PH_DATA;
                            end
                        end else begin
                            n_hdr_cnt = r_hdr_cnt + 5'd1;
                        end
                    end

                    tgad_pkg::PH_SKIP: begin
                        n_id_skip = r_id_skip - 8'd1;
                        if (r_id_skip == 8'd1) begin
                            n_phase = tgad_pkg::PH_DATA;
                        end
                    end

                    tgad_pkg::PH_DATA: begin
                        if (r_rle && r_packet_left == 8'd0) begin
                            // RLE packet header: count in low 7 bits, repeat flag on top
                            n_packet_left = {1'b0, i_item.data_byte[6:0]} + 8'd1;
                            n_repeat      = i_item.data_byte[7];
                            n_pbc         = '0;
                        end else begin
                            n_latch = ((r_pbc == 2'd0) ? 32'd0 : r_latch) |
                                      (32'(i_item.data_byte) << {r_pbc, 3'b000});
                            if (r_four ? (r_pbc != 2'd3) : (r_pbc != 2'd2)) begin
                                n_pbc = r_pbc + 2'd1;
                            end else begin
                                n_pbc = '0;
                                if (!r_four) begin
                                    n_latch[31:24] = 8'hFF;
                                end
                                if (r_rle) begin
                                    n_packet_left = r_packet_left - 8'd1;
                                    if (r_repeat && r_packet_left != 8'd1) begin
                                        n_run_active = 1'b1;
                                    end
                                end
                                w_emit = 1'b1;
                            end
                        end
                    end

                    default: ;
                endcase
            end
        end

        // Pixel out: index, column/row walk, end-of-image
        if (w_emit) begin
            w_idx      = r_row_start + IDX_W'(r_column);
            n_pix_left = r_pix_left - CNT_W'(1);
            if ({1'b0, r_column} + 17'd1 >= {1'b0, r_width}) begin
                n_column    = '0;
                n_row_start = r_flip ? r_row_start - IDX_W'(r_width) :
                                       r_row_start + IDX_W'(r_width);
            end else begin
                n_column = r_column + 16'd1;
            end
            w_last = (r_pix_left == CNT_W'(1));
            if (w_last) begin
                n_phase       = tgad_pkg::PH_DONE;
                n_run_active  = 1'b0;
                n_packet_left = '0;
            end
        end

        // Errors stop the decoder until reset
        if (w_err) begin
            n_phase      = tgad_pkg::PH_STOP;
            n_run_active = 1'b0;
        end
    end

    // Result fields
    always_comb begin
        o_res_valid        = w_emit || w_err;
        o_res.status       = w_err ? w_err_st : tgad_pkg::ST_PIXEL;
        o_res.pixel_index  = w_emit ? w_idx : '0;
        o_res.blue         = w_emit ? n_latch[7:0]   : 8'd0;
        o_res.green        = w_emit ? n_latch[15:8]  : 8'd0;
        o_res.red          = w_emit ? n_latch[23:16] : 8'd0;
        o_res.alpha        = w_emit ? n_latch[31:24] : 8'd0;
        o_res.last_pixel   = w_emit && w_last;
        o_res.run_pending  = w_emit && (n_phase == tgad_pkg::PH_DATA) && n_run_active;
        o_res.image_width  = n_width;
        o_res.image_height = n_height;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase       <= tgad_pkg::PH_HEADER;
            r_hdr_cnt     <= '0;
            r_id_skip     <= '0;
            r_rle         <= 1'b0;
            r_four        <= 1'b0;
            r_flip        <= 1'b0;
            r_width       <= '0;
            r_height      <= '0;
            r_pbc         <= '0;
            r_latch       <= '0;
            r_packet_left <= '0;
            r_repeat      <= 1'b0;
            r_column      <= '0;
            r_row_start   <= '0;
            r_pix_left    <= '0;
            r_type_bad    <= 1'b0;
            r_depth_bad   <= 1'b0;
            r_run_active  <= 1'b0;
        end else begin
            r_phase       <= n_phase;
            r_hdr_cnt     <= n_hdr_cnt;
            r_id_skip     <= n_id_skip;
            r_rle         <= n_rle;
            r_four        <= n_four;
            r_flip        <= n_flip;
            r_width       <= n_width;
            r_height      <= n_height;
            r_pbc         <= n_pbc;
            r_latch       <= n_latch;
            r_packet_left <= n_packet_left;
            r_repeat      <= n_repeat;
            r_column      <= n_column;
            r_row_start   <= n_row_start;
            r_pix_left    <= n_pix_left;
            r_type_bad    <= n_type_bad;
            r_depth_bad   <= n_depth_bad;
            r_run_active  <= n_run_active;
        end
    end

    // An error result parks the decoder in the stop phase
    `TGAD_ASSERT_NXT(a_err_stops, i_clk, i_rst_n, w_err, r_phase == tgad_pkg::PH_STOP)
    // The stop phase is left only by reset
    `TGAD_ASSERT_NXT(a_stop_sticky, i_clk, i_rst_n, r_phase == tgad_pkg::PH_STOP, r_phase == tgad_pkg::PH_STOP)
    // The final pixel ends the image
    `TGAD_ASSERT_NXT(a_last_done, i_clk, i_rst_n, w_emit && w_last, r_phase == tgad_pkg::PH_DONE)
    // A pending run always has copies left
    `TGAD_ASSERT_IMP(a_run_left, i_clk, i_rst_n, r_run_active, r_packet_left != 8'd0)
    // While decoding data at least one pixel is still owed
    `TGAD_ASSERT_IMP(a_pix_owed, i_clk, i_rst_n, r_phase == tgad_pkg::PH_DATA, r_pix_left != '0)

endmodule

`default_nettype wire

// ===== rtl/core/tgad_out_reg.sv =====
// Result register of the TGA decoder: holds one result until the sink takes it.
// Depends on tgad_pkg and tgad_out_if.
`default_nettype none

module tgad_out_reg (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               i_load,
    input  tgad_pkg::t_result i_res,
    output logic              o_can_load,
    tgad_out_if.source        o_out
);

    logic              r_valid;
    tgad_pkg::t_result r_res;

    // Free when empty or emptied this cycle
    assign o_can_load = !r_valid || o_out.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_can_load) begin
            r_valid <= i_load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_can_load && i_load) begin
            r_res <= i_res;
        end
    end

    assign o_out.valid        = r_valid;
    assign o_out.status       = r_res.status;
    assign o_out.pixel_index  = r_res.pixel_index;
    assign o_out.blue         = r_res.blue;
    assign o_out.green        = r_res.green;
    assign o_out.red          = r_res.red;
    assign o_out.alpha        = r_res.alpha;
    assign o_out.last_pixel   = r_res.last_pixel;
    assign o_out.run_pending  = r_res.run_pending;
    assign o_out.image_width  = r_res.image_width;
    assign o_out.image_height = r_res.image_height;

endmodule

`default_nettype wire

// ===== rtl/core/tga_rle_image_decoder.sv =====
// TGA true-color RLE decoder, streaming one file byte per item.
// Depends on tgad_pkg, tgad_ifs, tgad_in_reg, tgad_decode and tgad_out_reg.
//
// Usage:
//   i_in carries items: kind 0 is a file byte (data_byte), kind 1 asks for the
//   next copy of a pending repeat run, kind 2 marks end of file. o_out carries
//   one result per pixel (status 0, BGRA, destination index) or one error result.
//   Results with run_pending set ask the source for continue items (or bytes).
// Pipeline: an accepted item waits in the input register, then is decoded into
//   the result register, which drives its result onto o_out.
// Throughput: one item per cycle while o_out is not stalled; each item is handled
//   in one decode step (header counters, pixel assembler, incrementally kept row index).
// Reset: synchronous, active low; the decoder waits for a new header and both
//   registers empty. After an error or the last pixel all items are dropped
//   until reset.
// Stall: while a result waits on o_out the input register still takes one
//   item; i_in.ready falls only when both registers are full.
`default_nettype none

module tga_rle_image_decoder #(
    parameter int MAX_PIXELS = 1048576
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    tgad_in_if.sink     i_in,
    tgad_out_if.source  o_out
);

    logic              w_in_valid;
    tgad_pkg::t_item   w_item;
    logic              w_can_load;
    logic              w_step;
    logic              w_res_valid;
    tgad_pkg::t_result w_res;

    // Decode steps whenever an item waits and the result register is free
    assign w_step = w_in_valid && w_can_load;

    tgad_in_reg u_in_reg (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in      (i_in),
        .i_advance (w_can_load),
        .o_valid   (w_in_valid),
        .o_item    (w_item)
    );

    tgad_decode #(
        .MAX_PIXELS (MAX_PIXELS)
    ) u_decode (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_step      (w_step),
        .i_item      (w_item),
        .o_res_valid (w_res_valid),
        .o_res       (w_res)
    );

    tgad_out_reg u_out_reg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (w_step && w_res_valid),
        .i_res      (w_res),
        .o_can_load (w_can_load),
        .o_out      (o_out)
    );

endmodule

`default_nettype wire
